FILE: rtl/bsmms_pkg.sv
// Shared types and constants for the bounded set min/max span block.
package bsmms_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W = 9;

   localparam logic [DATA_W-1:0] SIGN_BIAS = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic [DATA_W-1:0] GAP_ONES = {DATA_W{1'b1}};
   localparam logic [CNT_W-1:0] CAPACITY_RESET = 9'd256;

   typedef logic [DATA_W-1:0] word_type;
   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic wr_en;
      logic gap_en;
      logic chain_clr;
      logic chain_en;
   } cell_ctl_type;

endpackage

FILE: rtl/bounded_set_min_max_span.sv
// Top level of the bounded set min/max span block: control, spans and cell row.
//
// Usage: pulse start with req_value and req_restart while busy is low; the word
// is taken at that edge. One result word follows per request, shown for one
// cycle with rsp_valid high; the receiver cannot stall it. busy is low again
// in the cycle where rsp_valid is high, so the next request may start there.
// A stored value runs through states GAP, SCAN and DONE; SCAN is skipped when
// n, the number of values held before it, is zero (as after restart), and its
// length grows with n. A rejected value goes straight to DONE. The gap minimum
// travels one cell per cycle down the row of DEPTH cells, one per stored value.
// csr_write_en with csr_write_data sets the capacity; write only while idle.
// Capacity above DEPTH acts as DEPTH.
// Reset (synchronous, active high) empties the store, sets capacity to 256
// and leaves the block idle; cell contents are not cleared and need no pass.
module bounded_set_min_max_span
   import bsmms_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic signed [31:0] req_value,
   input  logic              req_restart,
   output logic              rsp_valid,
   output logic              rsp_accepted,
   output logic [8:0]        rsp_held_count,
   output logic              rsp_spans_valid,
   output logic [31:0]       rsp_shortest_span,
   output logic [31:0]       rsp_longest_span,
   input  logic              csr_write_en,
   input  logic [8:0]        csr_write_data
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_GAP  = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0] state_ff, state_in;
   count_type  capacity_ff, capacity_in;
   count_type  held_total_ff, held_total_in;
   word_type   least_ff, least_in;
   word_type   greatest_ff, greatest_in;
   word_type   best_gap_ff, best_gap_in;
   count_type  scan_cnt_ff, scan_cnt_in;
   count_type  steps_ff, steps_in;
   logic       accepted_ff, accepted_in;
   word_type   newcomer_ff, newcomer_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_accepted_ff, rsp_accepted_in;
   count_type  rsp_count_ff, rsp_count_in;
   logic       rsp_spans_ff, rsp_spans_in;
   word_type   rsp_short_ff, rsp_short_in;
   word_type   rsp_long_ff, rsp_long_in;

   logic         take;
   count_type    limit;
   count_type    base_cnt;
   logic         fits;
   word_type     biased;
   word_type     merged_gap;
   logic         two_held;
   cell_ctl_type cell_ctl;
   word_type     gap_link [DEPTH:0];

   assign take     = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign limit    = (32'(capacity_ff) < DEPTH) ? capacity_ff : CNT_W'(DEPTH);
   assign base_cnt = req_restart ? '0 : held_total_ff;
   assign fits     = (base_cnt < limit);
   assign biased   = word_type'(req_value) ^ SIGN_BIAS;

   assign merged_gap = (gap_link[0] < best_gap_ff) ? gap_link[0] : best_gap_ff;
   assign two_held   = (held_total_ff >= CNT_W'(2));

   always_comb begin
      cell_ctl           = '0;
      cell_ctl.wr_en     = take && fits;
      cell_ctl.chain_clr = take;
      cell_ctl.gap_en    = (state_ff == ST_GAP);
      cell_ctl.chain_en  = (state_ff == ST_SCAN);
   end

   always_comb begin
      capacity_in = capacity_ff;
      if (csr_write_en) begin
         capacity_in = csr_write_data;
      end
   end

   always_comb begin
      state_in      = state_ff;
      held_total_in = held_total_ff;
      least_in      = least_ff;
      greatest_in   = greatest_ff;
      best_gap_in   = best_gap_ff;
      scan_cnt_in   = scan_cnt_ff;
      steps_in      = steps_ff;
      accepted_in   = accepted_ff;
      newcomer_in   = newcomer_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               scan_cnt_in = base_cnt;
               steps_in    = base_cnt;
               accepted_in = fits;
               newcomer_in = biased;
               if (req_restart) begin
                  least_in    = '0;
                  greatest_in = '0;
                  best_gap_in = GAP_ONES;
               end
               if (fits) begin
                  held_total_in = base_cnt + CNT_W'(1);
                  if (base_cnt == '0) begin
                     least_in    = biased;
                     greatest_in = biased;
                  end else begin
                     least_in    = (biased < least_ff) ? biased : least_ff;
                     greatest_in = (biased > greatest_ff) ? biased : greatest_ff;
                  end
                  state_in = ST_GAP;
               end else begin
                  held_total_in = base_cnt;
                  state_in      = ST_DONE;
               end
            end
         end
         ST_GAP: begin
            state_in = (steps_ff == '0) ? ST_DONE : ST_SCAN;
         end
         ST_SCAN: begin
            steps_in = steps_ff - CNT_W'(1);
            if (steps_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            best_gap_in = merged_gap;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in    = (state_ff == ST_DONE);
      rsp_accepted_in = rsp_accepted_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_spans_in    = rsp_spans_ff;
      rsp_short_in    = rsp_short_ff;
      rsp_long_in     = rsp_long_ff;
      if (state_ff == ST_DONE) begin
         rsp_accepted_in = accepted_ff;
         rsp_count_in    = held_total_ff;
         rsp_spans_in    = two_held;
         rsp_short_in    = two_held ? merged_gap : '0;
         rsp_long_in     = two_held ? (greatest_ff - least_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         capacity_ff   <= CAPACITY_RESET;
         held_total_ff <= '0;
         least_ff      <= '0;
         greatest_ff   <= '0;
         best_gap_ff   <= GAP_ONES;
         steps_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         capacity_ff   <= capacity_in;
         held_total_ff <= held_total_in;
         least_ff      <= least_in;
         greatest_ff   <= greatest_in;
         best_gap_ff   <= best_gap_in;
         steps_ff      <= steps_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff     <= scan_cnt_in;
      accepted_ff     <= accepted_in;
      newcomer_ff     <= newcomer_in;
      rsp_accepted_ff <= rsp_accepted_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_spans_ff    <= rsp_spans_in;
      rsp_short_ff    <= rsp_short_in;
      rsp_long_ff     <= rsp_long_in;
   end

   assign gap_link[DEPTH] = GAP_ONES;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      bsmms_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl_i      (cell_ctl),
         .wr_idx_i   (base_cnt),
         .wr_data_i  (biased),
         .scan_cnt_i (scan_cnt_ff),
         .newcomer_i (newcomer_ff),
         .gap_i      (gap_link[i+1]),
         .gap_o      (gap_link[i])
      );
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_held_count    = rsp_count_ff;
   assign rsp_spans_valid   = rsp_spans_ff;
   assign rsp_shortest_span = rsp_short_ff;
   assign rsp_longest_span  = rsp_long_ff;

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result word shown while busy");

   a_spans_need_two: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_spans_ff) |-> (rsp_count_ff >= CNT_W'(2)))
      else $error("spans reported with fewer than two values");

   a_short_le_long: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_spans_ff) |-> (rsp_short_ff <= rsp_long_ff))
      else $error("shortest span exceeds longest span");

   a_scan_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (steps_ff != '0))
      else $error("scan running with no steps left");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |=> busy)
      else $error("request taken without going busy");

endmodule

FILE: rtl/bsmms_cell.sv
// One storage cell: holds a value, its gap to the newcomer, and a stage of the min chain.
module bsmms_cell
   import bsmms_pkg::*;
#(
   parameter int unsigned INDEX = 0
) (
   input  logic         clock,
   input  cell_ctl_type ctl_i,
   input  count_type    wr_idx_i,
   input  word_type     wr_data_i,
   input  count_type    scan_cnt_i,
   input  word_type     newcomer_i,
   input  word_type     gap_i,
   output word_type     gap_o
);

   word_type value_ff, value_in;
   word_type own_gap_ff, own_gap_in;
   word_type chain_ff, chain_in;
   logic     occupied;
   logic     wr_hit;
   word_type abs_diff;

   assign occupied = (INDEX < 32'(scan_cnt_i));
   assign wr_hit   = ctl_i.wr_en && (32'(wr_idx_i) == INDEX);
   assign abs_diff = (newcomer_i >= value_ff) ? (newcomer_i - value_ff)
                                              : (value_ff - newcomer_i);

   always_comb begin
      value_in = value_ff;
      if (wr_hit) begin
         value_in = wr_data_i;
      end
   end

   always_comb begin
      own_gap_in = own_gap_ff;
      if (ctl_i.gap_en) begin
         own_gap_in = occupied ? abs_diff : GAP_ONES;
      end
   end

   // pass the smaller of this cell's gap and the upstream gap down the row; chain_clr sets it to all ones
   always_comb begin
      chain_in = chain_ff;
      if (ctl_i.chain_clr) begin
         chain_in = GAP_ONES;
      end else if (ctl_i.chain_en) begin
         chain_in = (own_gap_ff < gap_i) ? own_gap_ff : gap_i;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      own_gap_ff <= own_gap_in;
      chain_ff   <= chain_in;
   end

   assign gap_o = chain_ff;

endmodule

FILE: dv/tb_bounded_set_min_max_span.sv
// Testbench for bounded_set_min_max_span: queued stimulus, span predictor, result checks.
`timescale 1ns / 100ps

module tb_bounded_set_min_max_span;
   import bsmms_pkg::*;

   localparam real CLK_PERIOD = 4.0;
   localparam int STORE_DEPTH = 256;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PRINT_LIMIT = 50;
   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic restart;
      logic drain;
   } offer_word_type;

   typedef struct packed {
      logic accepted;
      count_type held_count;
      logic spans_valid;
      word_type shortest_span;
      word_type longest_span;
   } span_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [31:0] req_value = '0;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_accepted;
   logic [8:0] rsp_held_count;
   logic rsp_spans_valid;
   logic [31:0] rsp_shortest_span;
   logic [31:0] rsp_longest_span;
   logic csr_write_en = 1'b0;
   logic [8:0] csr_write_data = '0;

   offer_word_type pending_offers[$];
   span_result_type expected_spans[$];
   offer_word_type next_offer;
   span_result_type want;

   logic signed [DATA_W-1:0] held_vals[STORE_DEPTH];
   int held_n;
   logic signed [DATA_W-1:0] least_val;
   logic signed [DATA_W-1:0] greatest_val;
   word_type best_gap;
   int unsigned capacity_setting;

   int idle_left;
   bit idling_enabled;
   logic signed [DATA_W-1:0] near_base;
   int mismatch_count;
   int result_count;
   int cycle_count;

   bounded_set_min_max_span u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_value         (req_value),
      .req_restart       (req_restart),
      .rsp_valid         (rsp_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_held_count    (rsp_held_count),
      .rsp_spans_valid   (rsp_spans_valid),
      .rsp_shortest_span (rsp_shortest_span),
      .rsp_longest_span  (rsp_longest_span),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic clear_store();
      held_n = 0;
      least_val = '0;
      greatest_val = '0;
      best_gap = GAP_ONES;
   endtask

   task automatic predict_offer(input logic signed [DATA_W-1:0] value, input logic restart);
      span_result_type r;
      int unsigned limit_n;
      word_type gap;
      int i;
      if (restart) begin
         clear_store();
      end
      limit_n = (capacity_setting > STORE_DEPTH) ? STORE_DEPTH : capacity_setting;
      r = '0;
      if (held_n < limit_n) begin
         for (i = 0; i < held_n; i++) begin
            if (value >= held_vals[i]) begin
               gap = value - held_vals[i];
            end else begin
               gap = held_vals[i] - value;
            end
            if (gap < best_gap) begin
               best_gap = gap;
            end
         end
         if (held_n == 0) begin
            least_val = value;
            greatest_val = value;
         end else begin
            if (value < least_val) begin
               least_val = value;
            end
            if (value > greatest_val) begin
               greatest_val = value;
            end
         end
         held_vals[held_n] = value;
         held_n++;
         r.accepted = 1'b1;
      end
      r.held_count = count_type'(held_n);
      if (held_n >= 2) begin
         r.spans_valid = 1'b1;
         r.shortest_span = best_gap;
         r.longest_span = greatest_val - least_val;
      end
      expected_spans.insert(expected_spans.size(), r);
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("[%0t] result %0d mismatch: %s", $time, result_count, what);
      end
      mismatch_count++;
   endtask

   task automatic check_field(input string field_name, input logic [31:0] got,
                              input logic [31:0] expected_val);
      if (got !== expected_val) begin
         report_mismatch($sformatf("%s got %0h, expected %0h", field_name, got, expected_val));
      end
   endtask

   task automatic queue_offer(input logic signed [DATA_W-1:0] value, input logic restart,
                              input logic drain);
      offer_word_type w;
      w.value = value;
      w.restart = restart;
      w.drain = drain;
      pending_offers.insert(pending_offers.size(), w);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      int unsigned mode;
      logic signed [DATA_W-1:0] v;
      mode = $urandom_range(0, 9);
      if (mode <= 4) begin
         v = $urandom;
      end else if (mode <= 6) begin
         v = int'($urandom_range(0, 40)) - 20;
      end else if (mode == 7) begin
         case ($urandom_range(0, 5))
            0: v = VALUE_MIN;
            1: v = VALUE_MAX;
            2: v = '0;
            3: v = -1;
            4: v = VALUE_MIN + 1;
            default: v = VALUE_MAX - 1;
         endcase
      end else begin
         v = near_base + (int'($urandom_range(0, 6)) - 3);
      end
      return v;
   endfunction

   // hold until the queue is drained and every result word is in
   task automatic settle();
      while (pending_offers.size() != 0 || start || busy || expected_spans.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_capacity(input int unsigned cap);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= cap[8:0];
      capacity_setting = cap & 32'h1FF;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            predict_offer(req_value, req_restart);
         end
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left <= idle_left - 1;
               start <= 1'b0;
            end else if (pending_offers.size() != 0 &&
                         !(pending_offers[0].drain && expected_spans.size() != 0)) begin
               next_offer = pending_offers.pop_front();
               req_value <= next_offer.value;
               req_restart <= next_offer.restart;
               start <= 1'b1;
               if (idling_enabled && $urandom_range(0, 3) == 0) begin
                  idle_left <= $urandom_range(1, 14);
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_spans.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = expected_spans.pop_front();
            check_field("accepted", rsp_accepted, want.accepted);
            check_field("held_count", rsp_held_count, want.held_count);
            check_field("spans_valid", rsp_spans_valid, want.spans_valid);
            check_field("shortest_span", rsp_shortest_span, want.shortest_span);
            check_field("longest_span", rsp_longest_span, want.longest_span);
         end
         result_count++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** bounded_set_min_max_span: FAILED **");
         $finish;
      end
   end

   initial begin
      int unsigned cap;
      int seq_max;
      int budget;
      int seq_len;
      int phase;
      int k;
      mismatch_count = 0;
      result_count = 0;
      cycle_count = 0;
      idle_left = 0;
      near_base = '0;
      clear_store();
      capacity_setting = CAPACITY_RESET;
      idling_enabled = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // extremes, duplicates, restart at reset capacity
      queue_offer(VALUE_MIN, 1'b1, 1'b0);
      queue_offer(VALUE_MAX, 1'b0, 1'b0);
      queue_offer(0, 1'b0, 1'b0);
      queue_offer(-1, 1'b0, 1'b0);
      queue_offer(1, 1'b0, 1'b0);
      queue_offer(1, 1'b0, 1'b0);
      queue_offer(5, 1'b1, 1'b0);
      settle();

      // fill a small store and overflow it
      write_capacity(3);
      queue_offer(100, 1'b1, 1'b0);
      queue_offer(200, 1'b0, 1'b1);
      queue_offer(-50, 1'b0, 1'b0);
      queue_offer(999, 1'b0, 1'b0);
      queue_offer(VALUE_MIN, 1'b0, 1'b1);
      queue_offer(VALUE_MAX, 1'b1, 1'b0);
      queue_offer(VALUE_MAX - 1, 1'b0, 1'b0);
      settle();

      // reject everything
      write_capacity(0);
      queue_offer(7, 1'b0, 1'b0);
      queue_offer(7, 1'b1, 1'b0);
      queue_offer(VALUE_MIN, 1'b0, 1'b0);
      settle();

      write_capacity(1);
      queue_offer(3, 1'b1, 1'b0);
      queue_offer(4, 1'b0, 1'b0);
      queue_offer(4, 1'b1, 1'b0);

      for (phase = 0; phase < 12; phase++) begin
         case (phase)
            2: begin
               cap = 511;
               seq_max = 262;
               budget = 262;
            end
            5: begin
               cap = 256;
               seq_max = 60;
               budget = 150;
            end
            8: begin
               cap = 0;
               seq_max = 5;
               budget = 15;
            end
            10: begin
               cap = 300;
               seq_max = 40;
               budget = 60;
            end
            default: begin
               cap = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(1, 12);
               seq_max = cap + 3;
               budget = 55;
            end
         endcase
         settle();
         idling_enabled = (phase < 10) && ($urandom_range(0, 4) != 0);
         write_capacity(cap);
         while (budget > 0) begin
            seq_len = (phase == 2) ? seq_max : $urandom_range(1, seq_max);
            if (seq_len > budget) begin
               seq_len = budget;
            end
            near_base = $urandom;
            for (k = 0; k < seq_len; k++) begin
               queue_offer(pick_value(),
                           (k == 0 && $urandom_range(0, 9) != 0) ||
                           (phase != 2 && $urandom_range(0, 49) == 0),
                           $urandom_range(0, 59) == 0);
            end
            budget -= seq_len;
         end
      end
      settle();

      if (mismatch_count == 0 && expected_spans.size() == 0) begin
         $display("** bounded_set_min_max_span: PASSED **");
      end else begin
         $display("** bounded_set_min_max_span: FAILED **");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/bsmms_pkg.sv
rtl/bsmms_cell.sv
rtl/bounded_set_min_max_span.sv
dv/tb_bounded_set_min_max_span.sv
